@@ rtl/core/omce_pkg.sv @@
// omce_pkg: types and constants for the online mean/covariance estimator.
// No dependencies.
package omce_pkg;

  localparam int Dim     = 8;
  localparam int IdxW    = 3;
  localparam int EntW    = 6;
  localparam int DivW    = 64;
  localparam int DivCntW = 7;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic               action;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] sample_value;
    logic               last_element;
  } omce_in_t;

  typedef struct packed {
    logic signed [31:0] mean_value;
    logic signed [63:0] variance_value;
    logic               variance_valid;
    logic [31:0]        sample_count;
  } omce_out_t;

endpackage

@@ rtl/core/online_mean_covariance_estimator.sv @@
// Top level of the online mean/covariance estimator.
// Depends on omce_pkg. One shared 64-bit restoring divider plus multiplies in the SMUL and MMUL states.
//
//  channel | ports                          | direction
//  in      | in_valid, in_ready, in_data    | item in
//  out     | out_valid, out_ready, out_data | result out
//
// A push without last only stores its element. A push with last absorbs the vector:
// per scatter entry (64 entries) a multiply then a division, then per mean
// element a multiply then a division, before the next item is taken.
// A read presents its result after one division, or straight from the read
// state when the estimate is invalid. rst_n clears count, mean and
// scatter valid bits. The output register holds a result until transfer; no new
// item is taken while it is full.
module online_mean_covariance_estimator
  import omce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  omce_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output omce_out_t out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SMUL  = 3'd1;
  localparam logic [2:0] S_SDIV  = 3'd2;
  localparam logic [2:0] S_MMUL  = 3'd3;
  localparam logic [2:0] S_MDIV  = 3'd4;
  localparam logic [2:0] S_RDRD  = 3'd5;
  localparam logic [2:0] S_RDIV  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // storage
  logic signed [31:0] buf_r  [Dim];
  logic signed [31:0] mean_r [Dim];
  logic        [Dim-1:0] mean_vld_r;
  logic signed [63:0] scat_mem [Dim*Dim];
  logic [Dim*Dim-1:0] scat_vld_r;
  logic [31:0]        count_r;

  // working registers
  logic [EntW-1:0]    ent_r;
  logic [IdxW-1:0]    mi_r;
  logic signed [63:0] scat_rd_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] rmean_r;
  logic               rvalid_r;

  // shared divider: unsigned num/den, then rounding handled by pre-add
  logic [DivW-1:0]    dnum_r, dquo_r;
  logic [DivW:0]      drem_r;
  logic [DivW-1:0]    dden_r;
  logic [DivCntW-1:0] dcnt_r;
  logic               dneg_r;
  logic [DivW-1:0]    dmag_r;

  omce_out_t out_r;
  logic      out_vld_r;

  assign in_ready  = (state_r == S_IDLE) && !out_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  wire in_xfer = in_valid && in_ready;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647)       sat32 = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) sat32 = 32'h8000_0000;
    else                           sat32 = v[31:0];
  endfunction

  wire [EntW-1:0] ei = ent_r;
  wire signed [32:0] diff_i_raw =
    33'(buf_r[ei[5:3]]) - 33'(mean_vld_r[ei[5:3]] ? mean_r[ei[5:3]] : 32'sd0);
  wire signed [32:0] diff_j_raw =
    33'(buf_r[ei[2:0]]) - 33'(mean_vld_r[ei[2:0]] ? mean_r[ei[2:0]] : 32'sd0);
  wire signed [31:0] diff_i = sat32(64'(diff_i_raw));
  wire signed [31:0] diff_j = sat32(64'(diff_j_raw));

  wire [32:0] kp1 = {1'b0, count_r} + 33'd1;
  wire [31:0] rden = count_r - 32'(Dim + 2);

  // one divider step; a load cycle, 64 steps, then a finish cycle
  wire [DivW:0] rem_sh = {drem_r[DivW-1:0], dnum_r[DivW-1]};
  wire          rem_ge = rem_sh >= {1'b0, dden_r};
  wire [DivW:0] rem_nx = rem_ge ? rem_sh - {1'b0, dden_r} : rem_sh;
  wire          div_done = (dcnt_r == DivCntW'(DivW + 1));

  wire [63:0] pmag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);

  // scatter add with saturation
  wire signed [63:0] term_mag = signed'(dmag_r - dquo_r);
  wire signed [63:0] term = dneg_r ? -term_mag : term_mag;
  wire signed [63:0] scat_old = scat_vld_r[ent_r] ? scat_rd_r : 64'sd0;
  wire signed [64:0] scat_sum = 65'(scat_old) + 65'(term);
  wire signed [63:0] scat_new =
    (scat_sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF :
    (scat_sum < -65'sh0_8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000 : scat_sum[63:0];

  // signed quotient with saturation (magnitude up to 2^63)
  wire signed [63:0] q_signed =
    dneg_r ? (dquo_r[63] ? 64'sh8000_0000_0000_0000 : -signed'(dquo_r))
           : (dquo_r[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : signed'(dquo_r));

  // scatter read address: the requested entry while idle, else the working entry
  wire [EntW-1:0] scat_ra = (state_r == S_IDLE) ? {in_data.row, in_data.col} : ent_r;

  always_ff @(posedge clk) begin
    scat_rd_r <= scat_mem[scat_ra];
    if (state_r == S_SDIV && div_done) scat_mem[ent_r] <= scat_new;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) begin
        if (in_data.action == ACT_READ) state_nxt = S_RDRD;
        else if (in_data.last_element) state_nxt = S_SMUL;
      end
      S_SMUL: state_nxt = S_SDIV;
      S_SDIV: if (div_done) state_nxt = (ent_r == EntW'(Dim*Dim-1)) ? S_MMUL : S_SMUL;
      S_MMUL: state_nxt = S_MDIV;
      S_MDIV: if (div_done) state_nxt = (mi_r == IdxW'(Dim-1)) ? S_IDLE : S_MMUL;
      S_RDRD: state_nxt = rvalid_r ? S_RDIV : S_IDLE;
      S_RDIV: if (div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mean_vld_r <= '0;
      scat_vld_r <= '0;
      count_r    <= '0;
      out_vld_r  <= 1'b0;
      ent_r      <= '0;
      mi_r       <= '0;
      dcnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_vld_r && out_ready) out_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_xfer) begin
          mi_r <= '0;
          if (in_data.action == ACT_PUSH) begin
            ent_r <= '0;
            buf_r[in_data.row] <= in_data.sample_value;
          end else begin
            ent_r    <= {in_data.row, in_data.col};
            rvalid_r <= count_r > 32'(Dim + 2);
            rmean_r  <= mean_vld_r[in_data.row] ? mean_r[in_data.row] : 32'sd0;
          end
        end
        S_SMUL: begin
          prod_r <= 64'(diff_i) * 64'(diff_j);
          dcnt_r <= '0;
        end
        S_SDIV: begin
          if (dcnt_r == '0) begin
            // load: (|P| + d/2) / d
            dmag_r <= pmag;
            dneg_r <= prod_r[63];
            dnum_r <= pmag + 64'(kp1[32:1]);
            dden_r <= 64'(kp1);
            drem_r <= '0;
            dcnt_r <= dcnt_r + 1'b1;
          end else if (!div_done) begin
            drem_r <= rem_nx;
            dnum_r <= {dnum_r[DivW-2:0], 1'b0};
            dquo_r <= {dquo_r[DivW-2:0], rem_ge};
            dcnt_r <= dcnt_r + 1'b1;
          end else begin
            scat_vld_r[ent_r] <= 1'b1;
            ent_r <= ent_r + 1'b1;
          end
        end
        S_MMUL: begin
          prod_r <= 64'($signed({1'b0, count_r})) *
                    64'(mean_vld_r[mi_r] ? mean_r[mi_r] : 32'sd0)
                    + 64'(buf_r[mi_r]);
          dcnt_r <= '0;
        end
        S_MDIV: begin
          if (dcnt_r == '0) begin
            dneg_r <= prod_r[63];
            dnum_r <= pmag + 64'(kp1[32:1]);
            dden_r <= 64'(kp1);
            drem_r <= '0;
            dcnt_r <= dcnt_r + 1'b1;
          end else if (!div_done) begin
            drem_r <= rem_nx;
            dnum_r <= {dnum_r[DivW-2:0], 1'b0};
            dquo_r <= {dquo_r[DivW-2:0], rem_ge};
            dcnt_r <= dcnt_r + 1'b1;
          end else begin
            mean_r[mi_r]     <= sat32(q_signed);
            mean_vld_r[mi_r] <= 1'b1;
            mi_r <= mi_r + 1'b1;
            if (mi_r == IdxW'(Dim-1) && count_r != 32'hFFFF_FFFF)
              count_r <= count_r + 1'b1;
          end
        end
        S_RDRD: begin
          prod_r <= scat_vld_r[ent_r] ? scat_rd_r : 64'sd0;
          dcnt_r <= '0;
          if (!rvalid_r) begin
            out_r     <= '{rmean_r, 64'sd0, 1'b0, count_r};
            out_vld_r <= 1'b1;
          end
        end
        S_RDIV: begin
          if (dcnt_r == '0) begin
            dneg_r <= prod_r[63];
            dnum_r <= pmag + 64'(rden[31:1]);
            dden_r <= 64'(rden);
            drem_r <= '0;
            dcnt_r <= dcnt_r + 1'b1;
          end else if (!div_done) begin
            drem_r <= rem_nx;
            dnum_r <= {dnum_r[DivW-2:0], 1'b0};
            dquo_r <= {dquo_r[DivW-2:0], rem_ge};
            dcnt_r <= dcnt_r + 1'b1;
          end else begin
            out_r     <= '{rmean_r, q_signed, 1'b1, count_r};
            out_vld_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == S_RDRD || $past(state_r) == S_RDIV))
    else $error("result outside read");
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r >= $past(count_r)) else $error("count decreased");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= DivCntW'(DivW + 1)) else $error("divider overrun");

endmodule
